// ===== rtl/core/ufv_pkg.sv =====
`timescale 1ns / 1ps

package ufv_pkg;

    // request codes on the input channel; code 3 means nothing and is dropped
    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_TICK  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FINAL   = 3'd1,
        ST_BAD_HDR = 3'd2,
        ST_CRC_ERR = 3'd3,
        ST_CANCEL  = 3'd4
    } t_status;

    localparam int MAX_PAYLOAD_DEF = 256;
    localparam int PAGE_SIZE_DEF   = 4096;

    localparam int HDR_LEN     = 12;
    localparam int HDR_IDX_W   = $clog2(HDR_LEN);
    localparam int TRAILER_LEN = 4;

    localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd2000;
    localparam logic [7:0]  CANCEL_BYTE      = 8'h03;
    localparam logic [7:0]  MAGIC_0          = 8'h41;  // 'A'
    localparam logic [7:0]  MAGIC_1          = 8'h55;  // 'U'
    localparam logic [7:0]  MAGIC_2          = 8'h50;  // 'P'
    localparam logic [7:0]  MAGIC_3          = 8'h31;  // '1'
    localparam logic [31:0] CRC_POLY         = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT         = 32'hFFFF_FFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        t_req       kind;
        logic [7:0] data;
    } t_beat;

    typedef struct packed {
        logic  valid;
        t_beat beat;
    } t_queue_out;

    typedef struct packed {
        t_status     status;
        logic [31:0] frame_offset;
        logic [8:0]  payload_length;
        logic        session_ended;
    } t_result;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/ufv_front.sv =====
`timescale 1ns / 1ps

module ufv_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_req_type,
    input  logic [7:0]            i_data_byte,
    output ufv_pkg::t_queue_out   o_q,
    input  logic                  i_pop
);

    localparam int QCNT_W = ufv_pkg::QPTR_W + 1;

    ufv_pkg::t_beat r_mem [ufv_pkg::QUEUE_DEPTH];
    logic [ufv_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [ufv_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]          r_count, n_count;

    logic           full;
    logic           accept;
    logic           keep;
    logic           push;
    ufv_pkg::t_beat beat;

    assign full       = (r_count == QCNT_W'(ufv_pkg::QUEUE_DEPTH));
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    // classify: start, byte and tick are queued, the unused code is dropped
    always_comb begin
        keep      = 1'b0;
        beat.kind = ufv_pkg::REQ_TICK;
        beat.data = i_data_byte;
        unique case (i_req_type)
            ufv_pkg::REQ_START: begin
                keep      = 1'b1;
                beat.kind = ufv_pkg::REQ_START;
            end
            ufv_pkg::REQ_BYTE: begin
                keep      = 1'b1;
                beat.kind = ufv_pkg::REQ_BYTE;
            end
            ufv_pkg::REQ_TICK: begin
                keep      = 1'b1;
                beat.kind = ufv_pkg::REQ_TICK;
            end
            default: keep = 1'b0;
        endcase
    end

    assign push = accept && keep;

    always_comb begin
        n_wr_ptr = push  ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QCNT_W'(push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= beat;
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.beat  = r_mem[r_rd_ptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(ufv_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule

// ===== rtl/core/ufv_back.sv =====
`timescale 1ns / 1ps

module ufv_back #(
    parameter int MAX_PAYLOAD = ufv_pkg::MAX_PAYLOAD_DEF,
    parameter int PAGE_SIZE   = ufv_pkg::PAGE_SIZE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [15:0]          i_cfg_wr_data,
    input  ufv_pkg::t_queue_out  i_q,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ufv_pkg::t_result     o_result
);

    localparam int BC_W   = $clog2(ufv_pkg::HDR_LEN + MAX_PAYLOAD + ufv_pkg::TRAILER_LEN);
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int PAGE_W = $clog2(PAGE_SIZE);

    logic [15:0]       r_timeout;
    logic              r_session, n_session;
    logic [BC_W-1:0]   r_bc, n_bc;
    logic [31:0]       r_crc, n_crc;
    logic [31:0]       r_trl, n_trl;
    logic [15:0]       r_idle, n_idle;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [BC_W-1:0]   r_crc_end, n_crc_end;
    logic [BC_W-1:0]   r_last, n_last;
    logic [7:0]        r_hdr [ufv_pkg::HDR_LEN];
    logic              r_out_valid, n_out_valid;
    ufv_pkg::t_result  r_out, n_out;

    logic                        hdr_we;
    logic [ufv_pkg::HDR_IDX_W-1:0] hdr_idx;
    logic [7:0]                  b;
    logic [BC_W-1:0]             bc_eff;
    logic [31:0]                 crc_eff;
    logic [31:0]                 hdr_off;
    logic [15:0]                 hdr_n;
    logic [17:0]                 page_sum;
    logic                        hdr_bad;
    logic [31:0]                 trl_new;
    ufv_pkg::t_status            fin_status;

    assign b       = i_q.beat.data;
    assign o_pop   = i_q.valid && (!r_out_valid || !i_out_stall);
    assign hdr_off = {r_hdr[7], r_hdr[6], r_hdr[5], r_hdr[4]};
    assign hdr_n   = {r_hdr[9], r_hdr[8]};
    assign trl_new = {b, r_trl[31:8]};

    // payload + in-page offset must not run past the page end
    assign page_sum = 18'(hdr_n) + 18'(hdr_off[PAGE_W-1:0]);

    // header check, byte 11 is still on the input
    assign hdr_bad = (r_hdr[0] != ufv_pkg::MAGIC_0) || (r_hdr[1] != ufv_pkg::MAGIC_1) ||
                     (r_hdr[2] != ufv_pkg::MAGIC_2) || (r_hdr[3] != ufv_pkg::MAGIC_3) ||
                     (hdr_n > 16'(MAX_PAYLOAD)) ||
                     (r_hdr[10] != 8'h00) || (b != 8'h00) ||
                     (page_sum > 18'(PAGE_SIZE));

    assign fin_status = (~r_crc != trl_new) ? ufv_pkg::ST_CRC_ERR :
                        (r_len == '0)       ? ufv_pkg::ST_FINAL : ufv_pkg::ST_OK;

    always_comb begin
        n_session   = r_session;
        n_bc        = r_bc;
        n_crc       = r_crc;
        n_trl       = r_trl;
        n_idle      = r_idle;
        n_len       = r_len;
        n_crc_end   = r_crc_end;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        hdr_we      = 1'b0;
        hdr_idx     = '0;
        bc_eff      = r_bc;
        crc_eff     = r_crc;

        if (o_pop) begin
            unique case (i_q.beat.kind)
                ufv_pkg::REQ_START: begin
                    n_session = 1'b1;
                    n_bc      = '0;
                    n_crc     = ufv_pkg::CRC_INIT;
                    n_trl     = '0;
                    n_idle    = '0;
                end
                ufv_pkg::REQ_TICK: begin
                    if (r_session && (r_idle != 16'hFFFF)) begin
                        n_idle = r_idle + 16'd1;
                    end
                end
                ufv_pkg::REQ_BYTE: begin
                    if (r_session) begin
                        // idle gap too long: partial frame is dropped first
                        if (r_idle > r_timeout) begin
                            bc_eff  = '0;
                            crc_eff = ufv_pkg::CRC_INIT;
                            n_trl   = '0;
                        end
                        n_idle = '0;
                        if ((bc_eff == '0) && (b == ufv_pkg::CANCEL_BYTE)) begin
                            n_session   = 1'b0;
                            n_bc        = '0;
                            n_crc       = ufv_pkg::CRC_INIT;
                            n_trl       = '0;
                            n_out_valid = 1'b1;
                            n_out       = '{ufv_pkg::ST_CANCEL, 32'h0, 9'h0, 1'b1};
                        end else if (bc_eff < BC_W'(ufv_pkg::HDR_LEN)) begin
                            hdr_we  = 1'b1;
                            hdr_idx = bc_eff[ufv_pkg::HDR_IDX_W-1:0];
                            n_crc   = ufv_pkg::crc32_byte(crc_eff, b);
                            n_bc    = bc_eff + 1'b1;
                            if (bc_eff == BC_W'(ufv_pkg::HDR_LEN - 1)) begin
                                if (hdr_bad) begin
                                    n_session   = 1'b0;
                                    n_bc        = '0;
                                    n_crc       = ufv_pkg::CRC_INIT;
                                    n_trl       = '0;
                                    n_out_valid = 1'b1;
                                    n_out       = '{ufv_pkg::ST_BAD_HDR, 32'h0, 9'h0, 1'b1};
                                end else begin
                                    n_len     = hdr_n[LEN_W-1:0];
                                    n_crc_end = BC_W'(ufv_pkg::HDR_LEN) +
                                                BC_W'(hdr_n[LEN_W-1:0]);
                                    n_last    = BC_W'(ufv_pkg::HDR_LEN) +
                                                BC_W'(hdr_n[LEN_W-1:0]) +
                                                BC_W'(ufv_pkg::TRAILER_LEN - 1);
                                end
                            end
                        end else begin
                            // past the header a timeout cannot have fired
                            if (r_bc < r_crc_end) begin
                                n_crc = ufv_pkg::crc32_byte(r_crc, b);
                            end else begin
                                n_trl = trl_new;
                            end
                            n_bc = r_bc + 1'b1;
                            if (r_bc == r_last) begin
                                n_bc        = '0;
                                n_crc       = ufv_pkg::CRC_INIT;
                                n_trl       = '0;
                                n_session   = (fin_status == ufv_pkg::ST_OK);
                                n_out_valid = 1'b1;
                                n_out.status         = fin_status;
                                n_out.frame_offset   = hdr_off;
                                n_out.payload_length = 9'(r_len);
                                n_out.session_ended  = (fin_status != ufv_pkg::ST_OK);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= ufv_pkg::IDLE_TIMEOUT_RST;
            r_session   <= 1'b0;
            r_bc        <= '0;
            r_crc       <= ufv_pkg::CRC_INIT;
            r_trl       <= '0;
            r_idle      <= '0;
            r_len       <= '0;
            r_crc_end   <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            r_session   <= n_session;
            r_bc        <= n_bc;
            r_crc       <= n_crc;
            r_trl       <= n_trl;
            r_idle      <= n_idle;
            r_len       <= n_len;
            r_crc_end   <= n_crc_end;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (hdr_we) begin
            r_hdr[hdr_idx] <= b;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    a_ended_iff_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.status == ufv_pkg::ST_OK) != r_out.session_ended))
        else $error("session_ended disagrees with status");

    a_abort_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out.status == ufv_pkg::ST_BAD_HDR) ||
                         (r_out.status == ufv_pkg::ST_CANCEL)))
        |-> ((r_out.frame_offset == 32'h0) && (r_out.payload_length == 9'h0)))
        else $error("aborted frame carries offset or length");

    a_bc_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_session && (r_bc >= BC_W'(ufv_pkg::HDR_LEN))) |-> (r_bc <= r_last))
        else $error("byte count ran past frame end");

endmodule

// ===== rtl/core/update_frame_validator_top.sv =====
`timescale 1ns / 1ps

// Update frame validator. Takes start / byte / 1 ms tick requests and checks
// length-prefixed update frames ("AUP1", LE offset, LE length, reserved,
// payload, LE CRC-32) giving one verdict per frame. One beat per clock is
// sustained with no bubbles while the output is not stalled; a 4-deep queue
// sits between the input classifier and the frame checker and a single
// result register drives the output, so a stall on the output only reaches
// the input once the queue has filled. The CRC is a byte-wide update per
// header and payload beat. PAGE_SIZE must be a power of two. The idle timeout
// register may only be written while no request is in flight.
module update_frame_validator_top #(
    parameter int MAX_PAYLOAD = ufv_pkg::MAX_PAYLOAD_DEF,
    parameter int PAGE_SIZE   = ufv_pkg::PAGE_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_frame_offset,
    output logic [8:0]  o_payload_length,
    output logic        o_session_ended
);

    ufv_pkg::t_queue_out q;
    logic                pop;
    ufv_pkg::t_result    result;

    ufv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_data_byte (i_data_byte),
        .o_q         (q),
        .i_pop       (pop)
    );

    ufv_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .PAGE_SIZE   (PAGE_SIZE)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q           (q),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result      (result)
    );

    assign o_status         = result.status;
    assign o_frame_offset   = result.frame_offset;
    assign o_payload_length = result.payload_length;
    assign o_session_ended  = result.session_ended;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 20_000;
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef logic [7:0] t_bytes [$];

    typedef enum int {
        FK_GOOD,
        FK_BAD_MAGIC,
        FK_BAD_LEN,
        FK_BAD_RSVD,
        FK_PAGE_CROSS,
        FK_BAD_CRC,
        FK_STALE,
        FK_RESTART,
        FK_CANCEL,
        FK_NOISE
    } t_frame_kind;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_req_type    = ufv_pkg::REQ_TICK;
    logic [7:0]  i_data_byte   = '0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_status;
    logic [31:0] o_frame_offset;
    logic [8:0]  o_payload_length;
    logic        o_session_ended;

    // shadow of the block's state
    logic        sess_open  = 1'b0;
    int unsigned frame_pos  = 0;
    logic [7:0]  hdr_buf [ufv_pkg::HDR_LEN];
    logic [31:0] crc_acc    = ufv_pkg::CRC_INIT;
    logic [31:0] crc_rx     = '0;
    logic [15:0] quiet_ms   = '0;
    logic [15:0] timeout_ms = ufv_pkg::IDLE_TIMEOUT_RST;

    ufv_pkg::t_result pending_verdicts [$];
    ufv_pkg::t_result oldest;
    int      mismatches    = 0;
    int      lost_verdicts = 0;
    int      session_beats = 0;
    int      cycle_count   = 0;
    int      send_gap_pct  = 0;
    int      rcv_stall_pct = 0;
    int      hold_left     = 0;
    int      hold_req      = 0;
    int      hold_seen     = 0;

    update_frame_validator_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_frame_offset   (o_frame_offset),
        .o_payload_length (o_payload_length),
        .o_session_ended  (o_session_ended)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                $error("verdict with none pending: status %0d offset %h length %0d",
                       o_status, o_frame_offset, o_payload_length);
            end else begin
                oldest = pending_verdicts.pop_front();
                if (o_status !== oldest.status) begin
                    mismatches++;
                    $error("status: expected %0d, got %0d", oldest.status, o_status);
                end
                if (o_frame_offset !== oldest.frame_offset) begin
                    mismatches++;
                    $error("frame_offset: expected %h, got %h",
                           oldest.frame_offset, o_frame_offset);
                end
                if (o_payload_length !== oldest.payload_length) begin
                    mismatches++;
                    $error("payload_length: expected %0d, got %0d",
                           oldest.payload_length, o_payload_length);
                end
                if (o_session_ended !== oldest.session_ended) begin
                    mismatches++;
                    $error("session_ended: expected %0d, got %0d",
                           oldest.session_ended, o_session_ended);
                end
            end
        end
    end

    function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] d);
        logic [31:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ d[i]) c = (c >> 1) ^ ufv_pkg::CRC_POLY;
            else c = c >> 1;
        end
        return c;
    endfunction

    function automatic void clear_frame();
        frame_pos = 0;
        crc_acc   = ufv_pkg::CRC_INIT;
        crc_rx    = '0;
    endfunction

    function automatic void push_verdict(input ufv_pkg::t_status st, input logic [31:0] off,
                                         input logic [8:0] len);
        ufv_pkg::t_result v;
        v.status         = st;
        v.frame_offset   = off;
        v.payload_length = len;
        v.session_ended  = (st != ufv_pkg::ST_OK);
        pending_verdicts.push_back(v);
    endfunction

    function automatic void predict_verdict(input logic [1:0] req, input logic [7:0] b);
        logic [31:0]      off;
        int unsigned      n;
        int unsigned      room;
        ufv_pkg::t_status st;
        if (req == ufv_pkg::REQ_START) begin
            sess_open = 1'b1;
            clear_frame();
            quiet_ms = '0;
            return;
        end
        if (!sess_open || req == REQ_NONE) return;
        if (req == ufv_pkg::REQ_TICK) begin
            if (quiet_ms != 16'hFFFF) quiet_ms++;
            return;
        end
        if (quiet_ms > timeout_ms) clear_frame();
        quiet_ms = '0;
        if (frame_pos == 0 && b == ufv_pkg::CANCEL_BYTE) begin
            sess_open = 1'b0;
            clear_frame();
            push_verdict(ufv_pkg::ST_CANCEL, '0, '0);
            return;
        end
        if (frame_pos < ufv_pkg::HDR_LEN) begin
            hdr_buf[frame_pos] = b;
            crc_acc = crc32_update(crc_acc, b);
            frame_pos++;
            if (frame_pos < ufv_pkg::HDR_LEN) return;
            off  = {hdr_buf[7], hdr_buf[6], hdr_buf[5], hdr_buf[4]};
            n    = 32'({hdr_buf[9], hdr_buf[8]});
            room = ufv_pkg::PAGE_SIZE_DEF - (off % ufv_pkg::PAGE_SIZE_DEF);
            if (hdr_buf[0] != ufv_pkg::MAGIC_0 || hdr_buf[1] != ufv_pkg::MAGIC_1 ||
                hdr_buf[2] != ufv_pkg::MAGIC_2 || hdr_buf[3] != ufv_pkg::MAGIC_3 ||
                n > ufv_pkg::MAX_PAYLOAD_DEF || hdr_buf[10] != 8'h00 ||
                hdr_buf[11] != 8'h00 || n > room) begin
                sess_open = 1'b0;
                clear_frame();
                push_verdict(ufv_pkg::ST_BAD_HDR, '0, '0);
            end
            return;
        end
        off = {hdr_buf[7], hdr_buf[6], hdr_buf[5], hdr_buf[4]};
        n   = 32'({hdr_buf[9], hdr_buf[8]});
        if (frame_pos < ufv_pkg::HDR_LEN + n) crc_acc = crc32_update(crc_acc, b);
        else crc_rx = {b, crc_rx[31:8]};
        frame_pos++;
        if (frame_pos < ufv_pkg::HDR_LEN + n + ufv_pkg::TRAILER_LEN) return;
        if (~crc_acc != crc_rx) st = ufv_pkg::ST_CRC_ERR;
        else if (n == 0) st = ufv_pkg::ST_FINAL;
        else st = ufv_pkg::ST_OK;
        clear_frame();
        quiet_ms = '0;
        if (st != ufv_pkg::ST_OK) sess_open = 1'b0;
        push_verdict(st, off, 9'(n));
    endfunction

    function automatic t_bytes make_frame(input logic [31:0] off, input logic [15:0] len,
                                          input logic [15:0] rsvd);
        t_bytes      fr;
        logic [31:0] crc;
        int          body;
        body = (len <= ufv_pkg::MAX_PAYLOAD_DEF) ? int'(len) : 0;
        fr = '{ufv_pkg::MAGIC_0, ufv_pkg::MAGIC_1, ufv_pkg::MAGIC_2, ufv_pkg::MAGIC_3,
               off[7:0], off[15:8], off[23:16], off[31:24],
               len[7:0], len[15:8], rsvd[7:0], rsvd[15:8]};
        repeat (body) fr.push_back(8'($urandom));
        crc = ufv_pkg::CRC_INIT;
        foreach (fr[i]) crc = crc32_update(crc, fr[i]);
        crc = ~crc;
        for (int i = 0; i < 4; i++) fr.push_back(crc[8*i +: 8]);
        return fr;
    endfunction

    task automatic set_idling(input int send_pct, input int rcv_pct);
        send_gap_pct  = send_pct;
        rcv_stall_pct = rcv_pct;
    endtask

    task automatic send_beat(input logic [1:0] req, input logic [7:0] b);
        if ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (req == ufv_pkg::REQ_START || (sess_open && req != REQ_NONE)) session_beats++;
        predict_verdict(req, b);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_beat(ufv_pkg::REQ_TICK, 8'($urandom));
    endtask

    // bytes first..last of a frame, with a few short tick bursts that never exceed the timeout
    task automatic send_stream(input t_bytes fr, input int first, input int last);
        for (int i = first; i <= last; i++) begin
            if (timeout_ms > 0 && $urandom_range(99) < 6)
                send_ticks($urandom_range(timeout_ms < 3 ? int'(timeout_ms) : 3, 1));
            send_beat(ufv_pkg::REQ_BYTE, fr[i]);
        end
    endtask

    // lower valid, wait for every verdict, then let the queue run dry
    task automatic settle_block();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_verdicts.size() != 0) begin
            lost_verdicts += pending_verdicts.size();
            $error("%0d verdicts never arrived", pending_verdicts.size());
            pending_verdicts.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_idle_timeout(input logic [15:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        timeout_ms = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_frame(input t_frame_kind kind);
        t_bytes      fr;
        logic [31:0] off;
        logic [15:0] len;
        logic [15:0] rsvd;
        int          n;
        int          lo;
        int          cut;
        int          k;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 4) n = 0;
        else if (pick < 92) n = $urandom_range(8, 1);
        else if (pick < 97) n = $urandom_range(ufv_pkg::MAX_PAYLOAD_DEF - 1, 9);
        else n = ufv_pkg::MAX_PAYLOAD_DEF;
        if (kind == FK_PAGE_CROSS && n < 2) n = 2;
        if (kind == FK_PAGE_CROSS)
            lo = $urandom_range(ufv_pkg::PAGE_SIZE_DEF - 1, ufv_pkg::PAGE_SIZE_DEF - n + 1);
        else if (n > 0 && $urandom_range(9) == 0)
            lo = ufv_pkg::PAGE_SIZE_DEF - n;  // payload ends right on the page boundary
        else
            lo = $urandom_range(ufv_pkg::PAGE_SIZE_DEF - (n > 0 ? n : 1), 0);
        off = $urandom;
        off = (off / ufv_pkg::PAGE_SIZE_DEF) * ufv_pkg::PAGE_SIZE_DEF + 32'(lo);
        len = 16'(n);
        if (kind == FK_BAD_LEN)
            len = $urandom_range(1) ? 16'(ufv_pkg::MAX_PAYLOAD_DEF + 1)
                                    : 16'($urandom_range(65535, ufv_pkg::MAX_PAYLOAD_DEF + 1));
        rsvd = (kind == FK_BAD_RSVD) ? 16'($urandom_range(65535, 1)) : 16'h0000;
        fr = make_frame(off, len, rsvd);
        case (kind)
            FK_BAD_MAGIC: begin
                k = $urandom_range(3);
                fr[k] = fr[k] ^ 8'($urandom_range(255, 1));
                send_stream(fr, 0, ufv_pkg::HDR_LEN - 1);
            end
            FK_BAD_LEN, FK_BAD_RSVD, FK_PAGE_CROSS: begin
                send_stream(fr, 0, ufv_pkg::HDR_LEN - 1);
            end
            FK_BAD_CRC: begin
                k = $urandom_range(fr.size() - 1, ufv_pkg::HDR_LEN);
                fr[k] = fr[k] ^ 8'(1 << $urandom_range(7));
                send_stream(fr, 0, fr.size() - 1);
            end
            FK_STALE: begin
                cut = $urandom_range(fr.size() - 1, 1);
                send_stream(fr, 0, cut - 1);
                if ($urandom_range(1)) begin
                    send_ticks(int'(timeout_ms) + $urandom_range(3, 1));
                end else begin
                    // exactly at the timeout the partial frame survives
                    send_ticks(int'(timeout_ms));
                    send_stream(fr, cut, fr.size() - 1);
                end
            end
            FK_RESTART: begin
                cut = $urandom_range(fr.size() - 1, 1);
                send_stream(fr, 0, cut - 1);
                send_beat(ufv_pkg::REQ_START, 8'($urandom));
            end
            FK_CANCEL: begin
                send_beat(ufv_pkg::REQ_BYTE, ufv_pkg::CANCEL_BYTE);
            end
            FK_NOISE: begin
                repeat ($urandom_range(12, 1)) send_beat(2'($urandom), 8'($urandom));
            end
            default: begin
                send_stream(fr, 0, fr.size() - 1);
            end
        endcase
    endtask

    task automatic test_idle_requests();
        send_beat(ufv_pkg::REQ_TICK, 8'h00);
        send_beat(ufv_pkg::REQ_BYTE, ufv_pkg::MAGIC_0);
        send_beat(ufv_pkg::REQ_BYTE, ufv_pkg::CANCEL_BYTE);
        send_beat(REQ_NONE, 8'hFF);
        send_beat(ufv_pkg::REQ_START, 8'hFF);
        send_beat(REQ_NONE, 8'h00);
        send_beat(ufv_pkg::REQ_TICK, 8'hFF);
    endtask

    task automatic test_cancel();
        send_beat(ufv_pkg::REQ_START, 8'h00);
        send_beat(ufv_pkg::REQ_BYTE, ufv_pkg::CANCEL_BYTE);
        send_beat(ufv_pkg::REQ_BYTE, ufv_pkg::MAGIC_0);
    endtask

    task automatic test_final_frame();
        send_beat(ufv_pkg::REQ_START, 8'h00);
        send_stream(make_frame(32'hFFFF_FFFF, 16'd0, 16'h0000), 0, ufv_pkg::HDR_LEN + 3);
    endtask

    task automatic test_restart();
        t_bytes fr;
        fr = make_frame(32'hFFFF_FFFF, 16'd1, 16'h0000);
        send_beat(ufv_pkg::REQ_START, 8'h00);
        send_stream(fr, 0, 4);
        send_beat(ufv_pkg::REQ_START, 8'h00);
        send_stream(fr, 0, fr.size() - 1);
        fr = make_frame(32'h0000_0000, 16'd2, 16'h0000);
        fr[fr.size() - 1] = fr[fr.size() - 1] ^ 8'h80;
        send_stream(fr, 0, fr.size() - 1);
    endtask

    task automatic test_bad_headers();
        t_bytes fr;
        fr = make_frame(32'h0000_0010, 16'd4, 16'h0000);
        fr[3] = 8'h32;
        send_beat(ufv_pkg::REQ_START, 8'h00);
        send_stream(fr, 0, ufv_pkg::HDR_LEN - 1);
        send_beat(ufv_pkg::REQ_START, 8'h00);
        send_stream(make_frame(32'h0, 16'(ufv_pkg::MAX_PAYLOAD_DEF + 1), 16'h0),
                    0, ufv_pkg::HDR_LEN - 1);
        send_beat(ufv_pkg::REQ_START, 8'h00);
        send_stream(make_frame(32'h0, 16'd1, 16'h8000), 0, ufv_pkg::HDR_LEN - 1);
        send_beat(ufv_pkg::REQ_START, 8'h00);
        send_stream(make_frame(32'h0000_0FFF, 16'd2, 16'h0), 0, ufv_pkg::HDR_LEN - 1);
    endtask

    task automatic test_timeout_zero();
        t_bytes fr;
        settle_block();
        write_idle_timeout(16'd0);
        fr = make_frame(32'h0000_1000, 16'd3, 16'h0000);
        send_beat(ufv_pkg::REQ_START, 8'h00);
        send_stream(fr, 0, 4);
        send_ticks(1);
        send_stream(fr, 0, fr.size() - 1);
        send_stream(fr, 0, fr.size() - 1);
        send_ticks(1);
        send_stream(fr, 0, fr.size() - 1);
    endtask

    // the largest timeout keeps a partial frame across a long idle stretch
    task automatic test_timeout_max();
        t_bytes fr;
        settle_block();
        write_idle_timeout(16'hFFFF);
        fr = make_frame(32'h1234_5F00, 16'd8, 16'h0000);
        send_beat(ufv_pkg::REQ_START, 8'h00);
        send_stream(fr, 0, 4);
        send_ticks(300);
        send_stream(fr, 5, fr.size() - 1);
    endtask

    task automatic test_output_holdoff();
        settle_block();
        hold_req++;
        repeat (16) begin
            send_beat(ufv_pkg::REQ_START, 8'h00);
            send_beat(ufv_pkg::REQ_BYTE, ufv_pkg::CANCEL_BYTE);
        end
        settle_block();
        send_beat(ufv_pkg::REQ_START, 8'h00);
        repeat (6) send_frame(FK_GOOD);
        settle_block();
    endtask

    task automatic test_random_sessions(input int beat_budget, input logic [15:0] tmo);
        int          pick;
        t_frame_kind kind;
        settle_block();
        write_idle_timeout(tmo);
        session_beats = 0;
        while (session_beats < beat_budget) begin
            if (!sess_open || $urandom_range(99) < 2) begin
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(3, 1)) send_beat(2'($urandom), 8'($urandom));
                send_beat(ufv_pkg::REQ_START, 8'($urandom));
            end
            if ($urandom_range(9) == 0) send_ticks($urandom_range(2, 1));
            pick = $urandom_range(99);
            if (pick < 55) kind = FK_GOOD;
            else if (pick < 63) kind = FK_BAD_CRC;
            else if (pick < 67) kind = FK_BAD_MAGIC;
            else if (pick < 71) kind = FK_BAD_LEN;
            else if (pick < 75) kind = FK_BAD_RSVD;
            else if (pick < 79) kind = FK_PAGE_CROSS;
            else if (pick < 86) kind = FK_STALE;
            else if (pick < 90) kind = FK_RESTART;
            else if (pick < 95) kind = FK_CANCEL;
            else kind = FK_NOISE;
            send_frame(kind);
        end
    endtask

    initial begin
        foreach (hdr_buf[i]) hdr_buf[i] = 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(24, 61);
        test_idle_requests();
        test_cancel();
        test_final_frame();
        test_restart();
        test_bad_headers();
        test_random_sessions(700, 16'd9);

        set_idling(61, 24);
        test_timeout_zero();
        test_random_sessions(700, 16'd2);
        test_output_holdoff();

        set_idling(0, 0);
        test_timeout_max();
        test_random_sessions(600, 16'd0);

        settle_block();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && lost_verdicts == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
